/* design/codm_pkg.sv */
// ============================================================================
// codm_pkg: shared constants and types for the circle overlap degree block.
// Holds the capacity, the field widths and the command passed between parts.
// ============================================================================
package codm_pkg;

    localparam int MAX_CIRCLES = 16;
    localparam int IDX_W = $clog2(MAX_CIRCLES);
    localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
    localparam int OUT_MASK_W = 16;
    localparam int OUT_IDX_W = 4;
    localparam int RESULT_LIMIT = 16;

    // One circle handed from the front part to the back part.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0] r;
        logic stored;
        logic last;
        logic dropped;
    } t_cmd;

endpackage

/* design/codm_front.sv */
// ============================================================================
// codm_front: input stage.
// Accepts circles, decides whether each is stored or dropped, and pushes a
// command into a two-entry queue that feeds the back part.
// ============================================================================
module codm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic signed [15:0] i_center_x,
    input  logic signed [15:0] i_center_y,
    input  logic [14:0]       i_radius,
    input  logic              i_last_circle,
    output logic              o_cmd_valid,
    output codm_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_take
);
    import codm_pkg::*;

    t_cmd r_q [2];
    logic r_rd, r_wr;
    logic [1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_count, n_count;
    logic r_drop, n_drop;
    logic push;
    t_cmd cmd;

    assign o_stall = (r_fill == 2'd2);
    assign push = i_valid && !o_stall;

    // Classify the incoming circle against the set's fill level.
    always_comb begin
        cmd.x = i_center_x;
        cmd.y = i_center_y;
        cmd.r = i_radius;
        cmd.stored = (r_count < CNT_W'(MAX_CIRCLES));
        cmd.last = i_last_circle;
        cmd.dropped = r_drop || !cmd.stored;
        n_count = r_count;
        n_drop = r_drop;
        if (push) begin
            if (i_last_circle) begin
                n_count = '0;
                n_drop = 1'b0;
            end else begin
                n_count = cmd.stored ? r_count + 1'b1 : r_count;
                n_drop = cmd.dropped;
            end
        end
        n_fill = r_fill + {1'b0, push} - {1'b0, i_cmd_take};
    end

    // Queue pointers and set bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_fill <= '0;
            r_count <= '0;
            r_drop <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_count <= n_count;
            r_drop <= n_drop;
            if (push) r_wr <= !r_wr;
            if (i_cmd_take) r_rd <= !r_rd;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= cmd;
    end

    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd = r_q[r_rd];

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'd2) else $error("queue overfilled");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_take |-> o_cmd_valid) else $error("take from empty queue");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CIRCLES)) else $error("count overflow");

endmodule

/* design/codm_back.sv */
// ============================================================================
// codm_back: pair test engine.
// Stores circles, then on the last circle tests one pair per cycle through a
// two-stage squared-distance pipeline and emits the circles of maximum degree.
// ============================================================================
module codm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  codm_pkg::t_cmd    i_cmd,
    output logic              o_cmd_take,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [3:0]        o_circle_index,
    output logic [3:0]        o_overlap_count,
    output logic [15:0]       o_neighbour_mask,
    output logic              o_capacity_exceeded,
    output logic              o_last_result
);
    import codm_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_PAIR = 5'b00010,
        S_DRAIN = 5'b00100,
        S_SCAN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    logic signed [15:0] r_xs [MAX_CIRCLES];
    logic signed [15:0] r_ys [MAX_CIRCLES];
    logic [14:0] r_rs [MAX_CIRCLES];
    logic [MAX_CIRCLES-1:0] r_mask [MAX_CIRCLES];
    logic [CNT_W-1:0] r_deg [MAX_CIRCLES];
    logic [CNT_W-1:0] r_n, r_best;
    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic r_drop;
    logic [4:0] r_emitted;
    // Pipeline stage one: differences; stage two: squares.
    logic r_v1, r_v2;
    logic [IDX_W-1:0] r_i1, r_j1, r_i2, r_j2;
    logic [16:0] r_dx, r_dy;
    logic [15:0] r_rsum;
    logic [34:0] r_d2;
    logic [31:0] r_r2;
    logic hit;
    logic signed [16:0] dx, dy;
    logic more_pairs;
    logic qual;
    logic more;
    logic [MAX_CIRCLES-1:0] cand;
    logic [IDX_W-1:0] nxt;
    logic found;
    logic r_ov;

    assign o_cmd_take = (r_state == S_LOAD) && i_cmd_valid;
    assign hit = r_v2 && (r_d2 < {3'b000, r_r2});
    assign dx = {r_xs[r_i][15], r_xs[r_i]} - {r_xs[r_j][15], r_xs[r_j]};
    assign dy = {r_ys[r_i][15], r_ys[r_i]} - {r_ys[r_j][15], r_ys[r_j]};

    // Next candidate at or after r_k that carries the best degree, and whether
    // another one follows it, so the last result can be flagged when loaded.
    always_comb begin
        found = 1'b0;
        nxt = r_k;
        cand = '0;
        for (int m = MAX_CIRCLES - 1; m >= 0; m--) begin
            if (IDX_W'(m) >= r_k && CNT_W'(m) < r_n && r_deg[m] == r_best) begin
                cand[m] = 1'b1;
                found = 1'b1;
                nxt = IDX_W'(m);
            end
        end
        qual = found && (r_emitted < 5'(RESULT_LIMIT));
        more = ((cand & (cand - 1'b1)) != '0) &&
               (r_emitted + 1'b1 < 5'(RESULT_LIMIT));
        more_pairs = !(({1'b0, r_j} == r_n - 1'b1) && ({1'b0, r_i} == r_n - 2'd2));
    end

    // Control and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n <= '0;
            r_drop <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_PAIR);
            r_v2 <= r_v1;
            case (r_state)
                S_LOAD: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.stored) begin
                            r_xs[r_n[IDX_W-1:0]] <= i_cmd.x;
                            r_ys[r_n[IDX_W-1:0]] <= i_cmd.y;
                            r_rs[r_n[IDX_W-1:0]] <= i_cmd.r;
                        end
                        if (i_cmd.last) begin
                            r_n <= i_cmd.stored ? r_n + 1'b1 : r_n;
                            r_drop <= i_cmd.dropped;
                            for (int m = 0; m < MAX_CIRCLES; m++) begin
                                r_mask[m] <= '0;
                                r_deg[m] <= '0;
                            end
                            r_i <= '0;
                            r_j <= IDX_W'(1);
                            r_best <= '0;
                            r_k <= '0;
                            r_emitted <= '0;
                            if ((i_cmd.stored ? r_n + 1'b1 : r_n) >= CNT_W'(2))
                                r_state <= S_PAIR;
                            else
                                r_state <= S_DRAIN;
                        end else if (i_cmd.stored) begin
                            r_n <= r_n + 1'b1;
                        end
                    end
                end
                S_PAIR: begin
                    r_i1 <= r_i;
                    r_j1 <= r_j;
                    r_dx <= dx[16] ? 17'(-dx) : 17'(dx);
                    r_dy <= dy[16] ? 17'(-dy) : 17'(dy);
                    r_rsum <= {1'b0, r_rs[r_i]} + {1'b0, r_rs[r_j]};
                    if (!more_pairs) begin
                        r_state <= S_DRAIN;
                    end else if ({1'b0, r_j} == r_n - 1'b1) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + 2'd2;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // Maximum degree over stored circles, one per cycle.
                    if (CNT_W'(r_k) < r_n && r_deg[r_k] > r_best) r_best <= r_deg[r_k];
                    if (CNT_W'(r_k) + 1'b1 >= r_n) begin
                        r_k <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_ov || !i_stall) begin
                        if (qual) begin
                            r_ov <= 1'b1;
                            o_circle_index <= OUT_IDX_W'(nxt);
                            o_overlap_count <= 4'(r_deg[nxt]);
                            o_neighbour_mask <= OUT_MASK_W'(r_mask[nxt]);
                            o_capacity_exceeded <= r_drop;
                            o_last_result <= !more;
                            r_emitted <= r_emitted + 1'b1;
                            if (nxt == IDX_W'(MAX_CIRCLES - 1)) begin
                                r_k <= nxt;
                                r_n <= CNT_W'(nxt);
                            end else begin
                                r_k <= nxt + 1'b1;
                            end
                        end else begin
                            r_ov <= 1'b0;
                            r_n <= '0;
                            r_drop <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
            // Second stage: squares; then update degree and neighbour bits.
            r_i2 <= r_i1;
            r_j2 <= r_j1;
            r_d2 <= 35'(r_dx * r_dx) + 35'(r_dy * r_dy);
            r_r2 <= r_rsum * r_rsum;
            if (hit) begin
                r_deg[r_i2] <= r_deg[r_i2] + 1'b1;
                r_deg[r_j2] <= r_deg[r_j2] + 1'b1;
                r_mask[r_i2][r_j2] <= 1'b1;
                r_mask[r_j2][r_i2] <= 1'b1;
            end
        end
    end

    // A result is offered while the output register holds one.
    assign o_valid = r_ov && (r_state == S_EMIT);

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_EMIT) else $error("output outside emit");
    a_pair_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PAIR |-> r_i < r_j) else $error("bad pair order");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> !o_cmd_take) else $error("take while busy");

endmodule

/* design/circle_overlap_degree_max.sv */
// ============================================================================
// circle_overlap_degree_max: top level.
// Loads circles and reports the circles with the most overlaps.
// ============================================================================
// Circles load at one per cycle, unless o_stall holds them, into a short queue
// and store; the circle marked last starts evaluation, which tests one pair per
// cycle, drains the pipeline and then searches for the maximum degree.
// Results then leave one per cycle while i_stall is low.
module circle_overlap_degree_max (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic signed [15:0] i_center_x,
    input  logic signed [15:0] i_center_y,
    input  logic [14:0]       i_radius,
    input  logic              i_last_circle,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [3:0]        o_circle_index,
    output logic [3:0]        o_overlap_count,
    output logic [15:0]       o_neighbour_mask,
    output logic              o_capacity_exceeded,
    output logic              o_last_result
);
    import codm_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_take;

    // Front part: accepts and classifies circles.
    codm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_center_x, .i_center_y,
        .i_radius, .i_last_circle,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    // Back part: pair tests and result emission.
    codm_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .o_valid, .i_stall, .o_circle_index,
        .o_overlap_count, .o_neighbour_mask, .o_capacity_exceeded, .o_last_result
    );

endmodule
